### rtl/core/drc_pkg.sv
// Shared types, constants and helper functions of the decimal coded radix converter.
package drc_pkg;

   localparam int ValueW    = 63;                  // operand and result width
   localparam int ReqDataW  = 64;                  // value padded to whole bytes
   localparam int ReqUserW  = 2;                   // opcode
   localparam int RspDataW  = 64;                  // result padded to whole bytes
   localparam int RspUserW  = 1;                   // overflow
   localparam int NumCells  = 19;                  // decimal digits of a 63-bit value
   localparam int DigitW    = 4;                   // one decimal digit
   localparam int ChunkW    = 6;                   // binary bits folded into the chain per step
   localparam int NumChunks = 11;                  // ceil(ValueW / ChunkW)
   localparam int WorkW     = NumChunks * ChunkW;  // operand padded to whole chunks
   localparam int StepW     = 5;                   // step count, up to NumChunks + NumCells - 1
   localparam int IdxW      = 5;                   // digit index into the chain
   localparam int CellXW    = DigitW + ChunkW;     // digit times 64 plus carry
   localparam int DecRadix  = 10;
   localparam int OctBits   = 3;
   localparam int OctLsb    = OctBits * NumCells;  // first octal digit past the 19th
   localparam int Div10Mul  = 205;                 // floor(x * 205 / 2048) = x / 10 for x < 1024
   localparam int Div10Sh   = 11;
   localparam int Div10W    = CellXW + 8;

   localparam logic [ValueW-1:0] ResultMax = '1;

   typedef enum logic [1:0] {
      OP_TO_BIN   = 2'd0,
      OP_TO_OCT   = 2'd1,
      OP_FROM_BIN = 2'd2,
      OP_FROM_OCT = 2'd3
   } drc_op_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } drc_state_type;

   // Token handed from one digit cell to the next higher one.
   typedef struct packed {
      logic              active;
      logic [ChunkW-1:0] carry;
   } drc_link_type;

   // Quotient by ten of a cell's working value (at most 639).
   function automatic logic [ChunkW-1:0] div10(input logic [CellXW-1:0] x);
      logic [Div10W-1:0] prod;
      prod = Div10W'(x) * Div10W'(Div10Mul);
      return prod[Div10Sh +: ChunkW];
   endfunction

endpackage

### rtl/core/decimal_coded_radix_converter_unit.sv
// Top level of the decimal coded radix converter: sequencer, digit accumulator and output stage.
//
// Converts one operand per transfer. Opcodes 0 and 1 write the operand's binary or octal
// digits as a decimal numeral; opcodes 2 and 3 read the operand's decimal digits as binary
// or octal digits (digits above the radix keep their face value). A numeral above 2^63-1
// returns 2^63-1 with the overflow flag set. Opcodes 0 and 1 add one digit per cycle to the
// result through the multiply-accumulate; opcodes 2 and 3 feed the operand into a row of 19
// decimal digit cells 6 bits per cycle, and the accumulator reads each digit as soon as the
// carry wave has left it. The last digit waits while the output register still holds a result.
// A new transfer is taken in the cycle after a result is produced, while that result may still
// wait in the output register.
module decimal_coded_radix_converter_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [drc_pkg::ReqDataW-1:0] req_tdata,   // [62:0] value, [63] zero
   input  logic [drc_pkg::ReqUserW-1:0] req_tuser,   // [1:0] opcode
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [drc_pkg::RspDataW-1:0] rsp_tdata,   // [62:0] result, [63] zero
   output logic [drc_pkg::RspUserW-1:0] rsp_tuser    // [0] overflow
);
   import drc_pkg::*;

   drc_state_type      state_ff, state_in;
   drc_op_type         op_ff, op_in, req_op;
   logic [WorkW-1:0]   work_ff, work_in;
   logic [StepW-1:0]   step_ff, step_in;
   logic [IdxW-1:0]    idx_ff, idx_in;
   logic [ValueW-1:0]  acc_ff, acc_in;
   logic [ValueW-1:0]  weight_ff, weight_in;
   logic               ovf_ff, ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ValueW-1:0]  rsp_result_ff, rsp_result_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic               accept;
   logic               from_dec;
   logic               sum_go;
   logic               last_sum;
   logic               advance;
   logic [DigitW-1:0]  chain_digit;
   logic [DigitW-1:0]  digit;
   logic [ValueW-1:0]  prod;
   logic [ValueW-1:0]  sum_val;
   drc_link_type       feed;

   drc_chain u_chain (
      .clock   (clock),
      .reset   (reset),
      .clear   (accept),
      .link_i  (feed),
      .sel_i   (idx_ff),
      .digit_o (chain_digit)
   );

   always_comb begin
      req_op   = drc_op_type'(req_tuser);
      from_dec = (op_ff == OP_FROM_BIN) || (op_ff == OP_FROM_OCT);
      // decimal digit k is final once the carry wave has passed cell k
      sum_go   = !from_dec || (step_ff >= StepW'(NumChunks));
      last_sum = sum_go && (idx_ff == IdxW'(NumCells - 1));
      advance  = !last_sum || !rsp_valid_ff || rsp_tready;

      unique case (op_ff)
         OP_TO_BIN:   digit = DigitW'(work_ff[0]);
         OP_TO_OCT:   digit = DigitW'(work_ff[OctBits-1:0]);
         OP_FROM_BIN,
         OP_FROM_OCT: digit = chain_digit;
         default:     digit = chain_digit;
      endcase
      prod    = ValueW'(digit) * weight_ff;
      sum_val = acc_ff + prod;

      feed.active = (state_ff == ST_RUN) && from_dec && (step_ff < StepW'(NumChunks));
      feed.carry  = work_ff[WorkW-1 -: ChunkW];
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      work_in       = work_ff;
      step_in       = step_ff;
      idx_in        = idx_ff;
      acc_in        = acc_ff;
      weight_in     = weight_ff;
      ovf_in        = ovf_ff;
      rsp_result_in = rsp_result_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      req_tready    = 1'b0;
      accept        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               accept    = 1'b1;
               state_in  = ST_RUN;
               op_in     = req_op;
               work_in   = WorkW'(req_tdata[ValueW-1:0]);
               step_in   = '0;
               idx_in    = '0;
               acc_in    = '0;
               weight_in = ValueW'(1);
               // a numeral longer than 19 digits cannot fit
               unique case (req_op)
                  OP_TO_BIN:   ovf_in = |req_tdata[ValueW-1:NumCells];
                  OP_TO_OCT:   ovf_in = |req_tdata[ValueW-1:OctLsb];
                  OP_FROM_BIN,
                  OP_FROM_OCT: ovf_in = 1'b0;
                  default:     ovf_in = 1'b0;
               endcase
            end
         end
         ST_RUN: begin
            if (advance) begin
               step_in = step_ff + StepW'(1);
               unique case (op_ff)
                  OP_TO_BIN:   work_in = work_ff >> 1;
                  OP_TO_OCT:   work_in = work_ff >> OctBits;
                  OP_FROM_BIN,
                  OP_FROM_OCT: work_in = work_ff << ChunkW;
                  default:     work_in = work_ff;
               endcase
               if (sum_go) begin
                  idx_in = idx_ff + IdxW'(1);
                  acc_in = sum_val;
                  unique case (op_ff)
                     OP_TO_BIN,
                     OP_TO_OCT:   weight_in = (weight_ff << 3) + (weight_ff << 1);
                     OP_FROM_BIN: weight_in = weight_ff << 1;
                     OP_FROM_OCT: weight_in = weight_ff << OctBits;
                     default:     weight_in = weight_ff;
                  endcase
               end
               if (last_sum) begin
                  state_in      = ST_IDLE;
                  rsp_valid_in  = 1'b1;
                  rsp_result_in = ovf_ff ? ResultMax : sum_val;
                  rsp_ovf_in    = ovf_ff;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      work_ff       <= work_in;
      acc_ff        <= acc_in;
      weight_ff     <= weight_in;
      ovf_ff        <= ovf_in;
      rsp_result_ff <= rsp_result_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RspDataW'(rsp_result_ff);
   assign rsp_tuser  = RspUserW'(rsp_ovf_ff);

endmodule

### rtl/core/drc_cell.sv
// One decimal digit cell: folds a 6-bit carry into its digit and passes the overflow upward.
module drc_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear,
   input  drc_pkg::drc_link_type  link_i,
   output drc_pkg::drc_link_type  link_o,
   output logic [drc_pkg::DigitW-1:0] digit_o
);
   import drc_pkg::*;

   drc_link_type        link_ff, link_in;
   logic [DigitW-1:0]   digit_ff, digit_in;
   logic [CellXW-1:0]   x;
   logic [ChunkW-1:0]   q;
   logic [CellXW-1:0]   q_times_ten;

   always_comb begin
      // digit * 64 + carry, then split into digit and carry for the next cell
      x           = {digit_ff, link_i.carry};
      q           = div10(x);
      q_times_ten = CellXW'(q) * CellXW'(DecRadix);
      digit_in    = digit_ff;
      link_in     = '0;
      if (clear) begin
         digit_in = '0;
      end else if (link_i.active) begin
         digit_in       = DigitW'(x - q_times_ten);
         link_in.active = 1'b1;
         link_in.carry  = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= '0;
      end else begin
         link_ff <= link_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign link_o  = link_ff;
   assign digit_o = digit_ff;

endmodule

### rtl/core/drc_chain.sv
// Row of decimal digit cells turning a binary operand into decimal digits, lowest cell first.
module drc_chain (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  drc_pkg::drc_link_type      link_i,
   input  logic [drc_pkg::IdxW-1:0]   sel_i,
   output logic [drc_pkg::DigitW-1:0] digit_o
);
   import drc_pkg::*;

   drc_link_type      links  [NumCells];
   logic [DigitW-1:0] digits [NumCells];

   assign links[0] = link_i;

   for (genvar i = 0; i < NumCells; i++) begin : g_cell
      if (i < NumCells - 1) begin : g_mid
         drc_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .clear   (clear),
            .link_i  (links[i]),
            .link_o  (links[i+1]),
            .digit_o (digits[i])
         );
      end else begin : g_top
         // top digit never carries out for a 63-bit operand
         drc_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .clear   (clear),
            .link_i  (links[i]),
            .link_o  (),
            .digit_o (digits[i])
         );
      end
   end

   always_comb begin
      digit_o = '0;
      for (int i = 0; i < NumCells; i++) begin
         if (sel_i == IdxW'(i)) begin
            digit_o = digits[i];
         end
      end
   end

endmodule
